@@ rtl/hpd_pkg.sv @@
package hpd_pkg;

    // History depth default
    localparam int HISTORY_DEPTH_DEF = 2;

    // Field widths
    localparam int HEADING_W  = 12;
    localparam int RANGE_W    = 16;
    localparam int PULSE_W    = 12;
    localparam int KP_W       = 14;
    localparam int KD_W       = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Datapath widths
    localparam int ERR_W   = 12;   // wrapped heading error
    localparam int DE_W    = 13;   // error change
    localparam int P_W     = 27;   // kp * err
    localparam int D_W     = 24;   // kd * de
    localparam int PABS_W  = 25;   // |kp * err| < 2^25
    localparam int MAGIC_W = 26;
    localparam int Q_W     = 19;   // |kp * err| / 100
    localparam int SUM_W   = 26;   // pulse sum before clamp

    // Heading constants (tenths of a degree)
    localparam logic [HEADING_W:0] HEADING_FULL = 13'd3600;
    localparam logic [HEADING_W:0] HEADING_HALF = 13'd1800;
    localparam logic [HEADING_W:0] HEADING_STEP = 13'd20;

    // Pulse limits
    localparam logic [PULSE_W-1:0] PULSE_MIN = 12'd2031;
    localparam logic [PULSE_W-1:0] PULSE_MAX = 12'd3508;

    // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT, exact for x < 2^30
    localparam logic [MAGIC_W-1:0] RECIP_100   = 26'd42949673;
    localparam int                 RECIP_SHIFT = 32;
    localparam logic [PABS_W-1:0]  HUNDRED     = 25'd100;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KP           = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KD           = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_LEFT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_RIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_NEAR   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_FAR    = 3'd6;

    // Register reset values
    localparam logic [KP_W-1:0]      KP_RST           = 14'd27;
    localparam logic [KD_W-1:0]      KD_RST           = 10'd100;
    localparam logic [HEADING_W-1:0] START_RST        = 12'd0;
    localparam logic [PULSE_W-1:0]   CENTER_LEFT_RST  = 12'd2759;
    localparam logic [PULSE_W-1:0]   CENTER_RIGHT_RST = 12'd2779;
    localparam logic [RANGE_W-1:0]   RANGE_NEAR_RST   = 16'd40;
    localparam logic [RANGE_W-1:0]   RANGE_FAR_RST    = 16'd60;

    // Configuration seen by the pipeline
    typedef struct packed {
        logic [KP_W-1:0]    kp;
        logic [KD_W-1:0]    kd;
        logic [PULSE_W-1:0] center_left;
        logic [PULSE_W-1:0] center_right;
        logic [RANGE_W-1:0] range_near;
        logic [RANGE_W-1:0] range_far;
    } cfg_t;

    // State stage result
    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic signed [DE_W-1:0]  de;
        logic [HEADING_W-1:0]    target;
    } step_t;

    // Gain stage result
    typedef struct packed {
        logic signed [P_W-1:0]   p;
        logic signed [D_W-1:0]   d;
        logic signed [ERR_W-1:0] err;
        logic [HEADING_W-1:0]    target;
    } prod_t;

endpackage

@@ rtl/hpd_state.sv @@
module hpd_state #(
    parameter int HISTORY_DEPTH = hpd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  hpd_pkg::cfg_t                  cfg,
    input  logic                           start_load,
    input  logic [hpd_pkg::HEADING_W-1:0]  start_value,
    input  logic                           up_valid,
    output logic                           up_ready,
    input  logic [hpd_pkg::HEADING_W-1:0]  compass_heading,
    input  logic                           range_valid,
    input  logic [hpd_pkg::RANGE_W-1:0]    range_reading,
    output logic                           dn_valid,
    input  logic                           dn_ready,
    output hpd_pkg::step_t                 dn_word
);

    logic [hpd_pkg::RANGE_W-1:0]         hist_reg  [HISTORY_DEPTH];
    logic [hpd_pkg::RANGE_W-1:0]         hist_next [HISTORY_DEPTH];
    logic [hpd_pkg::HEADING_W-1:0]       desired_reg;
    logic signed [hpd_pkg::ERR_W-1:0]    prev_err_reg;
    logic                                valid_reg;
    hpd_pkg::step_t                      word_reg;
    hpd_pkg::step_t                      word_next;

    logic                                all_near;
    logic                                all_far;
    logic [hpd_pkg::HEADING_W:0]         cur_ext;
    logic [hpd_pkg::HEADING_W:0]         dn_step;
    logic [hpd_pkg::HEADING_W:0]         after_dn;
    logic [hpd_pkg::HEADING_W:0]         up_add;
    logic [hpd_pkg::HEADING_W:0]         up_step;
    logic [hpd_pkg::HEADING_W:0]         after_up;
    logic signed [hpd_pkg::HEADING_W+1:0] diff;
    logic signed [hpd_pkg::HEADING_W+1:0] diff_wrap;
    logic signed [hpd_pkg::HEADING_W+1:0] half_pos;
    logic signed [hpd_pkg::HEADING_W+1:0] half_neg;
    logic signed [hpd_pkg::HEADING_W+1:0] full_s;
    logic                                take;

    assign take     = up_valid && up_ready;
    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

    // History after shifting in the new reading
    always_comb
    begin
        for (int k = 0; k < HISTORY_DEPTH - 1; k++)
        begin
            hist_next[k] = hist_reg[k + 1];
        end
        hist_next[HISTORY_DEPTH-1] = range_reading;
    end

    // Range limit tests over the whole history
    always_comb
    begin
        all_near = 1'b1;
        all_far  = 1'b1;
        for (int k = 0; k < HISTORY_DEPTH; k++)
        begin
            if (hist_next[k] > cfg.range_near)
            begin
                all_near = 1'b0;
            end
            if (hist_next[k] < cfg.range_far)
            begin
                all_far = 1'b0;
            end
        end
    end

    // Desired heading: turn down first, then up, each wrapped once
    always_comb
    begin
        cur_ext = {1'b0, desired_reg};
        if (cur_ext < hpd_pkg::HEADING_STEP)
        begin
            dn_step = cur_ext + (hpd_pkg::HEADING_FULL - hpd_pkg::HEADING_STEP);
        end
        else
        begin
            dn_step = cur_ext - hpd_pkg::HEADING_STEP;
        end
        after_dn = (range_valid && all_near) ? dn_step : cur_ext;

        up_add = after_dn + hpd_pkg::HEADING_STEP;
        if (up_add > hpd_pkg::HEADING_FULL)
        begin
            up_step = up_add - hpd_pkg::HEADING_FULL;
        end
        else
        begin
            up_step = up_add;
        end
        after_up = (range_valid && all_far) ? up_step : after_dn;
    end

    // Heading error wrapped into +-half turn, and its change
    always_comb
    begin
        half_pos  = $signed({1'b0, hpd_pkg::HEADING_HALF});
        half_neg  = -half_pos;
        full_s    = $signed({1'b0, hpd_pkg::HEADING_FULL});
        diff      = $signed({2'b00, after_up[hpd_pkg::HEADING_W-1:0]})
                  - $signed({2'b00, compass_heading});
        if (diff > half_pos)
        begin
            diff_wrap = diff - full_s;
        end
        else if (diff < half_neg)
        begin
            diff_wrap = diff + full_s;
        end
        else
        begin
            diff_wrap = diff;
        end
        word_next.err    = diff_wrap[hpd_pkg::ERR_W-1:0];
        word_next.de     = $signed({word_next.err[hpd_pkg::ERR_W-1], word_next.err})
                         - $signed({prev_err_reg[hpd_pkg::ERR_W-1], prev_err_reg});
        word_next.target = after_up[hpd_pkg::HEADING_W-1:0];
    end

    // Controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < HISTORY_DEPTH; k++)
            begin
                hist_reg[k] <= '0;
            end
            desired_reg  <= hpd_pkg::START_RST;
            prev_err_reg <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (up_ready)
            begin
                valid_reg <= up_valid;
            end
            if (start_load)
            begin
                desired_reg <= start_value;
            end
            else if (take)
            begin
                desired_reg <= word_next.target;
            end
            if (take)
            begin
                prev_err_reg <= word_next.err;
                if (range_valid)
                begin
                    for (int k = 0; k < HISTORY_DEPTH; k++)
                    begin
                        hist_reg[k] <= hist_next[k];
                    end
                end
            end
        end
    end

    // Stage word
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg <= word_next;
        end
    end

endmodule

@@ rtl/hpd_gain.sv @@
module hpd_gain (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [hpd_pkg::KP_W-1:0]  kp,
    input  logic [hpd_pkg::KD_W-1:0]  kd,
    input  logic                      up_valid,
    output logic                      up_ready,
    input  hpd_pkg::step_t            up_word,
    output logic                      dn_valid,
    input  logic                      dn_ready,
    output hpd_pkg::prod_t            dn_word
);

    logic                           valid_reg;
    hpd_pkg::prod_t                 word_reg;
    hpd_pkg::prod_t                 word_next;
    logic signed [hpd_pkg::P_W-1:0] kp_ext;
    logic signed [hpd_pkg::P_W-1:0] err_ext;
    logic signed [hpd_pkg::D_W-1:0] kd_ext;
    logic signed [hpd_pkg::D_W-1:0] de_ext;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

    // Proportional and derivative products
    always_comb
    begin
        kp_ext  = $signed({{(hpd_pkg::P_W - hpd_pkg::KP_W){1'b0}}, kp});
        err_ext = $signed({{(hpd_pkg::P_W - hpd_pkg::ERR_W){up_word.err[hpd_pkg::ERR_W-1]}},
                           up_word.err});
        kd_ext  = $signed({{(hpd_pkg::D_W - hpd_pkg::KD_W){1'b0}}, kd});
        de_ext  = $signed({{(hpd_pkg::D_W - hpd_pkg::DE_W){up_word.de[hpd_pkg::DE_W-1]}},
                           up_word.de});
        word_next.p      = kp_ext * err_ext;
        word_next.d      = kd_ext * de_ext;
        word_next.err    = up_word.err;
        word_next.target = up_word.target;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            word_reg <= word_next;
        end
    end

endmodule

@@ rtl/hpd_drive.sv @@
module hpd_drive (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [hpd_pkg::PULSE_W-1:0]       center_left,
    input  logic [hpd_pkg::PULSE_W-1:0]       center_right,
    input  logic                              up_valid,
    output logic                              up_ready,
    input  hpd_pkg::prod_t                    up_word,
    output logic                              dn_valid,
    input  logic                              dn_ready,
    output logic [hpd_pkg::PULSE_W-1:0]       left_pulse,
    output logic [hpd_pkg::PULSE_W-1:0]       right_pulse,
    output logic signed [hpd_pkg::ERR_W-1:0]  heading_error,
    output logic [hpd_pkg::HEADING_W-1:0]     target_heading
);

    localparam int PROD_W = hpd_pkg::PABS_W + hpd_pkg::MAGIC_W;

    // Quotient stage
    logic                              qv_reg;
    logic                              q_ready;
    logic                              q_take;
    logic [hpd_pkg::PABS_W-1:0]        pabs_reg;
    logic [hpd_pkg::Q_W-1:0]           qmag_reg;
    logic                              pneg_reg;
    logic signed [hpd_pkg::D_W-1:0]    d_reg;
    logic signed [hpd_pkg::ERR_W-1:0]  qerr_reg;
    logic [hpd_pkg::HEADING_W-1:0]     qtarget_reg;
    logic [hpd_pkg::P_W-1:0]           pabs_full;
    logic [hpd_pkg::PABS_W-1:0]        pabs_next;
    logic [PROD_W-1:0]                 recip_prod;

    // Output stage
    logic                              ov_reg;
    logic                              o_take;
    logic [hpd_pkg::PULSE_W-1:0]       left_reg;
    logic [hpd_pkg::PULSE_W-1:0]       right_reg;
    logic signed [hpd_pkg::ERR_W-1:0]  err_reg;
    logic [hpd_pkg::HEADING_W-1:0]     target_reg;
    logic [hpd_pkg::PABS_W-1:0]        q100;
    logic                              rem_nz;
    logic signed [hpd_pkg::SUM_W-1:0]  q_s;
    logic signed [hpd_pkg::SUM_W-1:0]  d_s;
    logic signed [hpd_pkg::SUM_W-1:0]  right_sum;
    logic signed [hpd_pkg::SUM_W-1:0]  left_sum;
    logic signed [hpd_pkg::SUM_W-1:0]  right_adj;
    logic signed [hpd_pkg::SUM_W-1:0]  left_adj;

    function automatic logic [hpd_pkg::PULSE_W-1:0] clamp_pulse(
        input logic signed [hpd_pkg::SUM_W-1:0] v
    );
        logic signed [hpd_pkg::SUM_W-1:0] lo;
        logic signed [hpd_pkg::SUM_W-1:0] hi;
        lo = $signed({{(hpd_pkg::SUM_W - hpd_pkg::PULSE_W){1'b0}}, hpd_pkg::PULSE_MIN});
        hi = $signed({{(hpd_pkg::SUM_W - hpd_pkg::PULSE_W){1'b0}}, hpd_pkg::PULSE_MAX});
        if (v > hi)
        begin
            return hpd_pkg::PULSE_MAX;
        end
        else if (v < lo)
        begin
            return hpd_pkg::PULSE_MIN;
        end
        return v[hpd_pkg::PULSE_W-1:0];
    endfunction

    assign q_ready  = !ov_reg || dn_ready;
    assign up_ready = !qv_reg || q_ready;
    assign q_take   = up_valid && up_ready;
    assign o_take   = qv_reg && q_ready;

    // |p| / 100 by reciprocal multiply
    always_comb
    begin
        pabs_full  = up_word.p[hpd_pkg::P_W-1] ? 27'(-up_word.p) : 27'(up_word.p);
        pabs_next  = pabs_full[hpd_pkg::PABS_W-1:0];
        recip_prod = PROD_W'(pabs_next) * PROD_W'(hpd_pkg::RECIP_100);
    end

    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            pabs_reg    <= pabs_next;
            qmag_reg    <= recip_prod[hpd_pkg::RECIP_SHIFT +: hpd_pkg::Q_W];
            pneg_reg    <= up_word.p[hpd_pkg::P_W-1];
            d_reg       <= up_word.d;
            qerr_reg    <= up_word.err;
            qtarget_reg <= up_word.target;
        end
    end

    // Sums truncated toward zero: p = 100q + r, fix up when r and the
    // integer part have opposite signs
    always_comb
    begin
        q100   = hpd_pkg::PABS_W'(qmag_reg) * hpd_pkg::HUNDRED;
        rem_nz = (q100 != pabs_reg);
        q_s    = $signed({{(hpd_pkg::SUM_W - hpd_pkg::Q_W){1'b0}}, qmag_reg});
        if (pneg_reg)
        begin
            q_s = -q_s;
        end
        d_s = $signed({{(hpd_pkg::SUM_W - hpd_pkg::D_W){d_reg[hpd_pkg::D_W-1]}}, d_reg});

        right_sum = $signed({{(hpd_pkg::SUM_W - hpd_pkg::PULSE_W){1'b0}}, center_right})
                  + d_s + q_s;
        left_sum  = $signed({{(hpd_pkg::SUM_W - hpd_pkg::PULSE_W){1'b0}}, center_left})
                  - d_s - q_s;

        right_adj = right_sum;
        left_adj  = left_sum;
        if (rem_nz)
        begin
            // right remainder has the sign of p, left the opposite
            if (pneg_reg && right_sum > 0)
            begin
                right_adj = right_sum - 1;
            end
            else if (!pneg_reg && right_sum < 0)
            begin
                right_adj = right_sum + 1;
            end
            if (!pneg_reg && left_sum > 0)
            begin
                left_adj = left_sum - 1;
            end
            else if (pneg_reg && left_sum < 0)
            begin
                left_adj = left_sum + 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_take)
        begin
            left_reg   <= clamp_pulse(left_adj);
            right_reg  <= clamp_pulse(right_adj);
            err_reg    <= qerr_reg;
            target_reg <= qtarget_reg;
        end
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (up_ready)
            begin
                qv_reg <= up_valid;
            end
            if (q_ready)
            begin
                ov_reg <= qv_reg;
            end
        end
    end

    assign dn_valid       = ov_reg;
    assign left_pulse     = left_reg;
    assign right_pulse    = right_reg;
    assign heading_error  = err_reg;
    assign target_heading = target_reg;

endmodule

@@ rtl/heading_pd_thrust_control.sv @@
// Channel   Direction  Handshake              Word
// in        to block   in_valid / in_ready    compass_heading, range_valid, range_reading
// out       from block out_valid / out_ready  left_pulse, right_pulse, heading_error,
//                                             target_heading
// cfg       to block   cfg_we (no wait)       cfg_index, cfg_data
//
// One word in and one word out per cycle while out_ready holds; each word passes
// through the input register, state update, gain multipliers, divide by
// 100 by reciprocal multiply, and sum and clamp in the output register.
// The state loop (history, desired heading, previous error) closes within the state stage.
// Reset clears all valid bits, history and previous error, and loads the
// register defaults. Each stage holds its word only while the next is full and
// stalled, so empty stages keep taking words while a result waits.
module heading_pd_thrust_control #(
    parameter int HISTORY_DEPTH = hpd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [hpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hpd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [hpd_pkg::HEADING_W-1:0]     compass_heading,
    input  logic                              range_valid,
    input  logic [hpd_pkg::RANGE_W-1:0]       range_reading,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [hpd_pkg::PULSE_W-1:0]       left_pulse,
    output logic [hpd_pkg::PULSE_W-1:0]       right_pulse,
    output logic signed [hpd_pkg::ERR_W-1:0]  heading_error,
    output logic [hpd_pkg::HEADING_W-1:0]     target_heading
);

    hpd_pkg::cfg_t                  cfg_reg;
    logic                           start_load;

    logic                           iv_reg;
    logic [hpd_pkg::HEADING_W-1:0]  compass_reg;
    logic                           rvalid_reg;
    logic [hpd_pkg::RANGE_W-1:0]    reading_reg;

    logic                           st_ready;
    logic                           st_valid;
    hpd_pkg::step_t                 st_word;
    logic                           gn_ready;
    logic                           gn_valid;
    hpd_pkg::prod_t                 gn_word;
    logic                           dr_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp           <= hpd_pkg::KP_RST;
            cfg_reg.kd           <= hpd_pkg::KD_RST;
            cfg_reg.center_left  <= hpd_pkg::CENTER_LEFT_RST;
            cfg_reg.center_right <= hpd_pkg::CENTER_RIGHT_RST;
            cfg_reg.range_near   <= hpd_pkg::RANGE_NEAR_RST;
            cfg_reg.range_far    <= hpd_pkg::RANGE_FAR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hpd_pkg::REG_KP:
                begin
                    cfg_reg.kp <= cfg_data[hpd_pkg::KP_W-1:0];
                end
                hpd_pkg::REG_KD:
                begin
                    cfg_reg.kd <= cfg_data[hpd_pkg::KD_W-1:0];
                end
                hpd_pkg::REG_CENTER_LEFT:
                begin
                    cfg_reg.center_left <= cfg_data[hpd_pkg::PULSE_W-1:0];
                end
                hpd_pkg::REG_CENTER_RIGHT:
                begin
                    cfg_reg.center_right <= cfg_data[hpd_pkg::PULSE_W-1:0];
                end
                hpd_pkg::REG_RANGE_NEAR:
                begin
                    cfg_reg.range_near <= cfg_data[hpd_pkg::RANGE_W-1:0];
                end
                hpd_pkg::REG_RANGE_FAR:
                begin
                    cfg_reg.range_far <= cfg_data[hpd_pkg::RANGE_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // start heading goes straight into the desired heading
    assign start_load = cfg_we && (cfg_index == hpd_pkg::REG_START);

    // Input register
    assign in_ready = !iv_reg || st_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            iv_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            compass_reg <= compass_heading;
            rvalid_reg  <= range_valid;
            reading_reg <= range_reading;
        end
    end

    hpd_state #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_state (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .start_load      (start_load),
        .start_value     (cfg_data[hpd_pkg::HEADING_W-1:0]),
        .up_valid        (iv_reg),
        .up_ready        (st_ready),
        .compass_heading (compass_reg),
        .range_valid     (rvalid_reg),
        .range_reading   (reading_reg),
        .dn_valid        (st_valid),
        .dn_ready        (gn_ready),
        .dn_word         (st_word)
    );

    hpd_gain u_gain (
        .clk      (clk),
        .rst_n    (rst_n),
        .kp       (cfg_reg.kp),
        .kd       (cfg_reg.kd),
        .up_valid (st_valid),
        .up_ready (gn_ready),
        .up_word  (st_word),
        .dn_valid (gn_valid),
        .dn_ready (dr_ready),
        .dn_word  (gn_word)
    );

    hpd_drive u_drive (
        .clk            (clk),
        .rst_n          (rst_n),
        .center_left    (cfg_reg.center_left),
        .center_right   (cfg_reg.center_right),
        .up_valid       (gn_valid),
        .up_ready       (dr_ready),
        .up_word        (gn_word),
        .dn_valid       (out_valid),
        .dn_ready       (out_ready),
        .left_pulse     (left_pulse),
        .right_pulse    (right_pulse),
        .heading_error  (heading_error),
        .target_heading (target_heading)
    );

endmodule
